// File: rtl/rtp_pkg.sv
// rtp_pkg: shared types, widths and codes for the rigid transform datapath
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rtp_pkg;

    // coordinate and coefficient formats
    localparam int COORD_WIDTH = 20;
    localparam int COEF_WIDTH  = 18;
    localparam int COORD_FRAC  = 8;
    localparam int COEF_FRAC   = COEF_WIDTH - 2;
    localparam int AXES        = 3;

    // derived datapath widths
    localparam int ROW_WIDTH   = AXES * COEF_WIDTH;
    localparam int TRANS_WIDTH = AXES * COORD_WIDTH;
    localparam int CFG_WIDTH   = (ROW_WIDTH > TRANS_WIDTH) ? ROW_WIDTH : TRANS_WIDTH;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = COEF_WIDTH + DIFF_WIDTH;
    localparam int RND_WIDTH   = PROD_WIDTH + 1 - COEF_FRAC;
    localparam int SUM_WIDTH   = RND_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_VEC_WORLD  = 2'd0,
        OP_VEC_OBJECT = 2'd1,
        OP_PT_WORLD   = 2'd2,
        OP_PT_OBJECT  = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROT_ROW0    = 2'd0,
        CFG_ROT_ROW1    = 2'd1,
        CFG_ROT_ROW2    = 2'd2,
        CFG_TRANSLATION = 2'd3
    } cfg_idx_t;

    // transfer payloads
    typedef struct packed {
        op_t    operation;
        coord_t in_x;
        coord_t in_y;
        coord_t in_z;
    } in_item_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   overflow;
    } out_item_t;

    // control from the pipeline front to the merging stage
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

// File: rtl/rtp_lane.sv
// rtp_lane: one output row; three coefficient products, rounding and sum
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_lane
    import rtp_pkg::*;
(
    input  logic   clk,
    input  logic   advance,
    input  coef_t  coef [AXES],
    input  diff_t  vin  [AXES],
    input  coord_t p_add,
    output sum_t   sum
);

    localparam logic signed [PROD_WIDTH:0] RND_HALF = (PROD_WIDTH + 1)'(1) << (COEF_FRAC - 1);

    logic signed [PROD_WIDTH-1:0] prod_reg [AXES];
    coord_t                       p_reg;
    sum_t                         sum_reg;
    sum_t                         sum_next;

    // product stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                prod_reg[c] <= coef[c] * vin[c];
            end
            p_reg <= p_add;
        end
    end

    // round each product to nearest (ties up) and add the offset
    always_comb
    begin
        logic signed [PROD_WIDTH:0]  ext;
        logic signed [RND_WIDTH-1:0] rnd;
        sum_next = SUM_WIDTH'(p_reg);
        for (int c = 0; c < AXES; c++)
        begin
            ext      = {prod_reg[c][PROD_WIDTH-1], prod_reg[c]} + RND_HALF;
            rnd      = ext[PROD_WIDTH:COEF_FRAC];
            sum_next = sum_next + SUM_WIDTH'(rnd);
        end
    end

    // sum stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// File: rtl/rtp_merge.sv
// rtp_merge: saturates the three lane sums, ORs the overflow flags, holds the result
// depends on rtp_pkg
`timescale 1ns / 1ps

module rtp_merge
    import rtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  sum_t      sum [AXES],
    output logic      out_valid,
    output out_item_t out_item
);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    coord_t    sat [AXES];
    logic      ovf [AXES];

    // clamp each sum to the coordinate range
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            ovf[r] = (sum[r][SUM_WIDTH-1:COORD_WIDTH-1] != {(SUM_WIDTH-COORD_WIDTH+1){1'b0}})
                  && (sum[r][SUM_WIDTH-1:COORD_WIDTH-1] != {(SUM_WIDTH-COORD_WIDTH+1){1'b1}});
            if (ovf[r])
            begin
                sat[r] = sum[r][SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
            end
            else
            begin
                sat[r] = sum[r][COORD_WIDTH-1:0];
            end
        end
        out_item_next.out_x    = sat[0];
        out_item_next.out_y    = sat[1];
        out_item_next.out_z    = sat[2];
        out_item_next.overflow = ovf[0] | ovf[1] | ovf[2];
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            out_valid_reg <= ctl.valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: rtl/rigid_transform_point_vector.sv
// rigid_transform_point_vector: rigid frame transform of one coordinate triple per transfer
// a result passes the input, product, sum and output registers in turn when not stalled
// throughput: one transfer per cycle when not stalled, set by three row lanes of three multipliers each
// stalls hold the whole pipeline; no input transfer is taken while the output waits
// reset: rotation is the identity, translation zero, pipeline and output empty
`timescale 1ns / 1ps

module rigid_transform_point_vector
    import rtp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item
);

    logic [ROW_WIDTH-1:0]   rot_row_reg [AXES];
    logic [TRANS_WIDTH-1:0] trans_reg;

    coef_t     rot  [AXES][AXES];
    coord_t    trans [AXES];
    coord_t    in_v [AXES];
    diff_t     v_next [AXES];
    diff_t     v_reg  [AXES];
    op_t       op_reg;
    logic      valid_a_reg;
    logic      valid_b_reg;
    logic      valid_c_reg;
    logic      advance;
    logic      transposed;
    coef_t     lane_coef [AXES][AXES];
    coord_t    lane_p [AXES];
    sum_t      lane_sum [AXES];
    pipe_ctl_t merge_ctl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                rot_row_reg[r] <= ROW_WIDTH'(1 << COEF_FRAC) << (r * COEF_WIDTH);
            end
            trans_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROT_ROW0:    rot_row_reg[0] <= cfg_data[ROW_WIDTH-1:0];
                CFG_ROT_ROW1:    rot_row_reg[1] <= cfg_data[ROW_WIDTH-1:0];
                CFG_ROT_ROW2:    rot_row_reg[2] <= cfg_data[ROW_WIDTH-1:0];
                CFG_TRANSLATION: trans_reg      <= cfg_data[TRANS_WIDTH-1:0];
                default:         trans_reg      <= trans_reg;
            endcase
        end
    end

    // unpack the frame
    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            trans[r] = trans_reg[r*COORD_WIDTH +: COORD_WIDTH];
            for (int c = 0; c < AXES; c++)
            begin
                rot[r][c] = rot_row_reg[r][c*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    // pipeline moves whenever the output register is free or being taken
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // input stage: point to object subtracts the origin first
    assign in_v[0] = in_item.in_x;
    assign in_v[1] = in_item.in_y;
    assign in_v[2] = in_item.in_z;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (in_item.operation == OP_PT_OBJECT)
            begin
                v_next[i] = DIFF_WIDTH'(in_v[i]) - DIFF_WIDTH'(trans[i]);
            end
            else
            begin
                v_next[i] = DIFF_WIDTH'(in_v[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg <= in_item.operation;
            for (int i = 0; i < AXES; i++)
            begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    // coefficient routing: object-space modes use the transpose
    assign transposed = (op_reg == OP_VEC_OBJECT) || (op_reg == OP_PT_OBJECT);

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            lane_p[r] = (op_reg == OP_PT_WORLD) ? trans[r] : '0;
            for (int c = 0; c < AXES; c++)
            begin
                lane_coef[r][c] = transposed ? rot[c][r] : rot[r][c];
            end
        end
    end

    // one lane per output row
    for (genvar r = 0; r < AXES; r++)
    begin : g_lane
        rtp_lane u_lane (
            .clk     (clk),
            .advance (advance),
            .coef    (lane_coef[r]),
            .vin     (v_reg),
            .p_add   (lane_p[r]),
            .sum     (lane_sum[r])
        );
    end

    // saturation and output register
    assign merge_ctl.advance = advance;
    assign merge_ctl.valid   = valid_c_reg;

    rtp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (merge_ctl),
        .sum       (lane_sum),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // overflow is only reported with a clamped component
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.overflow) |->
            (out_item.out_x == {1'b0, {(COORD_WIDTH-1){1'b1}}})
         || (out_item.out_x == {1'b1, {(COORD_WIDTH-1){1'b0}}})
         || (out_item.out_y == {1'b0, {(COORD_WIDTH-1){1'b1}}})
         || (out_item.out_y == {1'b1, {(COORD_WIDTH-1){1'b0}}})
         || (out_item.out_z == {1'b0, {(COORD_WIDTH-1){1'b1}}})
         || (out_item.out_z == {1'b1, {(COORD_WIDTH-1){1'b0}}}))
        else $error("overflow flag without a saturated component");

    // an empty output never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register is empty");

    // an accepted transfer passes the input, product, sum and output registers as the pipeline moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
        else $error("result lost in the pipeline");

    // stage valid bits hold while the pipeline is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable({valid_a_reg, valid_b_reg, valid_c_reg}))
        else $error("pipeline moved during a stall");

endmodule

// File: test/rigid_transform_point_vector_checker.sv
// rigid_transform_point_vector_checker: watches the config port and both channels of the block
// predicts each result from its own copy of the frame registers and compares it field by field
// depends on rtp_pkg for widths, codes and payload types
`timescale 1ns / 1ps

module rigid_transform_point_vector_checker
    import rtp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_item,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_item,
    output int                   errors,
    output int                   pending
);

    // shadow copy of the frame registers
    logic [ROW_WIDTH-1:0]   rot_rows [AXES];
    logic [TRANS_WIDTH-1:0] origin;

    // predicted results in transfer order
    out_item_t predicted_q [$];
    out_item_t want;

    // rotate, and translate where the operation asks, with per-product rounding and saturation
    function automatic out_item_t transform(in_item_t item);
        longint    coord [AXES];
        longint    shift [AXES];
        longint    acc;
        longint    prod;
        longint    sat_hi;
        longint    sat_lo;
        coef_t     coef;
        coord_t    res [AXES];
        logic      clipped;
        logic      use_transpose;
        out_item_t result;
        sat_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        sat_lo = -sat_hi - 1;
        clipped = 1'b0;
        use_transpose = (item.operation == OP_VEC_OBJECT) || (item.operation == OP_PT_OBJECT);
        coord[0] = longint'($signed(item.in_x));
        coord[1] = longint'($signed(item.in_y));
        coord[2] = longint'($signed(item.in_z));
        for (int r = 0; r < AXES; r++)
        begin
            shift[r] = longint'($signed(coord_t'(origin[r*COORD_WIDTH +: COORD_WIDTH])));
        end
        // point to object: exact difference, no saturation here
        if (item.operation == OP_PT_OBJECT)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                coord[r] = coord[r] - shift[r];
            end
        end
        for (int r = 0; r < AXES; r++)
        begin
            acc = 0;
            for (int c = 0; c < AXES; c++)
            begin
                if (use_transpose)
                    coef = coef_t'(rot_rows[c][r*COEF_WIDTH +: COEF_WIDTH]);
                else
                    coef = coef_t'(rot_rows[r][c*COEF_WIDTH +: COEF_WIDTH]);
                prod = longint'($signed(coef)) * coord[c];
                // round half up, then floor
                acc = acc + ((prod + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
            end
            if (item.operation == OP_PT_WORLD)
                acc = acc + shift[r];
            if (acc > sat_hi)
            begin
                acc = sat_hi;
                clipped = 1'b1;
            end
            else if (acc < sat_lo)
            begin
                acc = sat_lo;
                clipped = 1'b1;
            end
            res[r] = coord_t'(acc);
        end
        result.out_x    = res[0];
        result.out_y    = res[1];
        result.out_z    = res[2];
        result.overflow = clipped;
        return result;
    endfunction

    // track transfers and register writes at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                rot_rows[r] = '0;
                rot_rows[r][r*COEF_WIDTH + COEF_FRAC] = 1'b1;
            end
            origin = '0;
            predicted_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            // result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (predicted_q.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    errors = errors + 1;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (out_item.out_x !== want.out_x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.out_x, out_item.out_x);
                        errors = errors + 1;
                    end
                    if (out_item.out_y !== want.out_y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.out_y, out_item.out_y);
                        errors = errors + 1;
                    end
                    if (out_item.out_z !== want.out_z)
                    begin
                        $error("out_z: expected %0d, got %0d", want.out_z, out_item.out_z);
                        errors = errors + 1;
                    end
                    if (out_item.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow,
                               out_item.overflow);
                        errors = errors + 1;
                    end
                end
            end

            // input transfer uses the frame as it stood before this edge
            if (in_valid && !in_stall)
                predicted_q.push_back(transform(in_item));

            // register write, bits above the register width dropped
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROT_ROW0:    rot_rows[0] = cfg_data[ROW_WIDTH-1:0];
                    CFG_ROT_ROW1:    rot_rows[1] = cfg_data[ROW_WIDTH-1:0];
                    CFG_ROT_ROW2:    rot_rows[2] = cfg_data[ROW_WIDTH-1:0];
                    CFG_TRANSLATION: origin      = cfg_data[TRANS_WIDTH-1:0];
                    default:         ;
                endcase
            end

            pending <= predicted_q.size();
        end
    end

endmodule

// File: test/rigid_transform_point_vector_tb.sv
// rigid_transform_point_vector_tb: clock, reset and stimulus for the rigid transform block
// directed extremes first, then random frames and items under several idle and stall mixes
// depends on rtp_pkg, rigid_transform_point_vector and rigid_transform_point_vector_checker
`timescale 1ns / 1ps

module rigid_transform_point_vector_tb;
    import rtp_pkg::*;

    localparam int FRAMES_PER_PHASE = 6;
    localparam int ITEMS_PER_FRAME  = 62;
    localparam int SETTLE_CYCLES    = 8;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t COORD_ZERO = '0;
    localparam coef_t  COEF_MAX  = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t  COEF_MIN  = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam coef_t  COEF_ONE  = coef_t'(1) <<< COEF_FRAC;
    localparam int     FRAC_ONE  = 1 << COEF_FRAC;

    // kinds of random rotation coefficients
    localparam int COEF_UNIT     = 0;
    localparam int COEF_FULL     = 1;
    localparam int COEF_FRACTION = 2;
    localparam int COEF_EXTREME  = 3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_item;

    int errors;
    int pending;
    int send_idle_pct;
    int stall_pct;

    op_t all_ops [4]     = '{OP_VEC_WORLD, OP_VEC_OBJECT, OP_PT_WORLD, OP_PT_OBJECT};
    int  phase_idle [4]  = '{0, 79, 0, 36};
    int  phase_stall [4] = '{0, 0, 79, 36};

    rigid_transform_point_vector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    rigid_transform_point_vector_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .errors    (errors),
        .pending   (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall, redrawn every cycle
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // half full range, some small values, a few extremes
    function automatic coord_t rand_coord();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return coord_t'($urandom);
        else if (pick < 8)
            return coord_t'(int'($urandom_range(8192)) - 4096);
        else if (pick == 8)
            return COORD_MAX;
        return COORD_MIN;
    endfunction

    function automatic coef_t rand_coef(int kind);
        int unsigned pick;
        pick = $urandom_range(2);
        case (kind)
            COEF_UNIT:     return (pick == 0) ? coef_t'(0) : ((pick == 1) ? COEF_ONE : -COEF_ONE);
            COEF_FULL:     return coef_t'($urandom);
            COEF_FRACTION: return coef_t'(int'($urandom_range(2 * FRAC_ONE)) - FRAC_ONE);
            default:       return (pick == 0) ? COEF_MIN : COEF_MAX;
        endcase
    endfunction

    // one item transfer, with random idle cycles ahead of it
    task automatic send_item(input op_t op, input coord_t x, input coord_t y, input coord_t z);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op, x, y, z};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold off input until every predicted result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write; the caller lowers the write enable after the last one
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_WIDTH-1:0] word);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
    endtask

    // random frame, junk in the unused bits above each row
    task automatic load_frame(input int kind, input bit zero_origin);
        logic [CFG_WIDTH-1:0] word;
        for (int r = 0; r < AXES; r++)
        begin
            word = CFG_WIDTH'({$urandom, $urandom});
            for (int c = 0; c < AXES; c++)
                word[c*COEF_WIDTH +: COEF_WIDTH] = rand_coef(kind);
            write_reg(cfg_idx_t'(r), word);
        end
        word = '0;
        if (!zero_origin)
        begin
            for (int c = 0; c < AXES; c++)
                word[c*COORD_WIDTH +: COORD_WIDTH] = rand_coord();
        end
        write_reg(CFG_TRANSLATION, word);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_ROT_ROW0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_item       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset frame: identity rotation, zero origin, every operation at the extremes
        foreach (all_ops[i])
        begin
            send_item(all_ops[i], COORD_MAX, COORD_MAX, COORD_MAX);
            send_item(all_ops[i], COORD_MIN, COORD_MIN, COORD_MIN);
            send_item(all_ops[i], COORD_MAX, COORD_MIN, COORD_ZERO);
        end
        drain_results();

        // extreme coefficients, origin at both ends of the range, ones above each row
        write_reg(CFG_ROT_ROW0, {{(CFG_WIDTH-ROW_WIDTH){1'b1}}, COEF_MAX, COEF_MIN, COEF_MAX});
        write_reg(CFG_ROT_ROW1, {{(CFG_WIDTH-ROW_WIDTH){1'b1}}, COEF_MIN, COEF_MIN, COEF_MIN});
        write_reg(CFG_ROT_ROW2, {{(CFG_WIDTH-ROW_WIDTH){1'b1}}, COEF_MIN, COEF_MAX, coef_t'(0)});
        write_reg(CFG_TRANSLATION, {COORD_ZERO, COORD_MIN, COORD_MAX});
        cfg_write <= 1'b0;

        // point difference wider than a coordinate, then saturation both ways
        send_item(OP_PT_OBJECT, COORD_MIN, COORD_MAX, COORD_ZERO);
        send_item(OP_PT_OBJECT, COORD_MAX, COORD_MIN, coord_t'(-1));
        send_item(OP_PT_WORLD, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(OP_VEC_WORLD, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(OP_VEC_OBJECT, COORD_MAX, COORD_MIN, coord_t'(1));
        send_item(OP_PT_WORLD, coord_t'(256), coord_t'(-256), coord_t'(128));

        // random frames and items under each idle and stall mix
        foreach (phase_idle[ph])
        begin
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                drain_results();
                send_idle_pct = phase_idle[ph];
                stall_pct     = phase_stall[ph];
                load_frame(int'($urandom_range(COEF_EXTREME)), ($urandom_range(3) == 0));
                for (int n = 0; n < ITEMS_PER_FRAME; n++)
                    send_item(op_t'($urandom_range(3)), rand_coord(), rand_coord(), rand_coord());
            end
        end

        drain_results();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rtp_pkg.sv
rtl/rtp_lane.sv
rtl/rtp_merge.sv
rtl/rigid_transform_point_vector.sv
test/rigid_transform_point_vector_checker.sv
test/rigid_transform_point_vector_tb.sv
